// ===== rtl/core/modular_inverse_ext_euclid_unit_defines.svh =====
// Assertion macros used by the checker file of the modular inverse unit.
`ifndef MODULAR_INVERSE_EXT_EUCLID_UNIT_DEFINES_SVH
`define MODULAR_INVERSE_EXT_EUCLID_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define MIE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define MIE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/mie_pkg.sv =====
// Shared types and constants of the modular inverse unit.
`default_nettype none
package mie_pkg;

	// Modulus after reset, truncated to the data width where it is used.
	localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ALIGN,
		ST_DIVIDE,
		ST_END,
		ST_FINISH
	} mie_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic div_init;
		logic shift;
		logic div_step;
		logic step_end;
		logic capture;
	} mie_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic r1_zero;
		logic can_shift;
		logic k_zero;
		logic rem_zero;
	} mie_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/mie_ctrl.sv =====
// Controller state machine of the modular inverse unit.
`default_nettype none
module mie_ctrl
	import mie_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire mie_sts_t  sts,
	output mie_cmd_t       cmd,
	output logic           busy,
	output logic           done
);

	mie_state_t state_q;
	mie_state_t state_d;
	logic       done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_FINISH);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = sts.r1_zero ? ST_FINISH : ST_ALIGN;
			end
			ST_ALIGN: begin
				if (!sts.can_shift) state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (sts.k_zero) state_d = ST_END;
			end
			ST_END: begin
				state_d = sts.rem_zero ? ST_FINISH : ST_ALIGN;
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:   cmd.load     = start;
			ST_CHECK:  cmd.div_init = !sts.r1_zero;
			ST_ALIGN:  cmd.shift    = sts.can_shift;
			ST_DIVIDE: cmd.div_step = 1'b1;
			ST_END:    cmd.step_end = 1'b1;
			ST_FINISH: cmd.capture  = 1'b1;
			default:   cmd = '0;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule
`default_nettype wire

// ===== rtl/core/mie_datapath.sv =====
// Datapath of the modular inverse unit: remainder and coefficient pairs and a shift-subtract divider.
`default_nettype none
module mie_datapath
	import mie_pkg::*;
#(
	parameter int DATA_WIDTH = 31
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [DATA_WIDTH-1:0] cfg_modulus,
	input  wire logic [DATA_WIDTH-1:0] value,
	input  wire mie_cmd_t              cmd,
	output mie_sts_t                   sts,
	output logic [DATA_WIDTH-1:0]      inverse,
	output logic [DATA_WIDTH-1:0]      gcd_value,
	output logic                       no_inverse
);

	localparam int DW = DATA_WIDTH;
	localparam int SW = DATA_WIDTH + 1;
	localparam int TW = DATA_WIDTH + 2;
	localparam int KW = $clog2(DATA_WIDTH);

	logic        [DW-1:0] mod_q;
	logic        [DW-1:0] r0_q;
	logic        [DW-1:0] r1_q;
	logic signed [SW-1:0] s0_q;
	logic signed [SW-1:0] s1_q;
	logic        [DW-1:0] rem_q;
	logic        [DW-1:0] d_q;
	logic signed [TW-1:0] t_q;
	logic        [KW-1:0] k_q;

	logic        [DW-1:0] d_dbl;
	logic                 ge;
	logic        [DW-1:0] rem_n;
	logic signed [TW-1:0] t_n;
	logic signed [TW-1:0] s_new;
	logic signed [SW-1:0] s_norm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MODULUS_RESET[DW-1:0];
		end else if (cfg_we) begin
			mod_q <= cfg_modulus;
		end
	end

	assign d_dbl = {d_q[DW-2:0], 1'b0};
	assign ge    = (rem_q >= d_q);
	assign rem_n = ge ? (rem_q - d_q) : rem_q;
	// Horner accumulation of quotient times s1, quotient bits arrive MSB first.
	assign t_n   = (t_q <<< 1) + (ge ? TW'(s1_q) : TW'(0));
	assign s_new = TW'(s0_q) - t_q;
	assign s_norm = s0_q + $signed({1'b0, mod_q});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r0_q <= value;
			r1_q <= mod_q;
			s0_q <= SW'(1);
			s1_q <= '0;
		end
		if (cmd.div_init) begin
			rem_q <= r0_q;
			d_q   <= r1_q;
			t_q   <= '0;
			k_q   <= '0;
		end
		if (cmd.shift) begin
			d_q <= d_dbl;
			k_q <= k_q + KW'(1);
		end
		if (cmd.div_step) begin
			rem_q <= rem_n;
			t_q   <= t_n;
			d_q   <= d_q >> 1;
			k_q   <= k_q - KW'(1);
		end
		if (cmd.step_end) begin
			r0_q  <= r1_q;
			r1_q  <= rem_q;
			s0_q  <= s1_q;
			s1_q  <= s_new[SW-1:0];
			// The next division divides the old divisor by this remainder.
			rem_q <= r1_q;
			d_q   <= rem_q;
			t_q   <= '0;
			k_q   <= '0;
		end
		if (cmd.capture) begin
			inverse    <= s0_q[SW-1] ? s_norm[DW-1:0] : s0_q[DW-1:0];
			gcd_value  <= r0_q;
			no_inverse <= (r0_q != DW'(1));
		end
	end

	always_comb begin
		sts.r1_zero   = (r1_q == '0);
		sts.can_shift = !d_q[DW-1] && (d_dbl <= rem_q);
		sts.k_zero    = (k_q == '0);
		sts.rem_zero  = (rem_q == '0);
	end

endmodule
`default_nettype wire

// ===== rtl/core/modular_inverse_ext_euclid_unit.sv =====
// Top level of the modular inverse unit (extended Euclidean algorithm).
// Sequence: the modulus is tested, then each Euclid step aligns the divisor, divides by
// shift-subtract and updates the pairs, and a finish state captures the result.
// done pulses the cycle after the finish cycle; the shift-subtract divider sets the pace.
// One item at a time; a new item may be accepted in the cycle in which done pulses.
// Reset clears the controller to idle and loads the modulus with 1000000007.
`default_nettype none
module modular_inverse_ext_euclid_unit
	import mie_pkg::*;
#(
	parameter int DATA_WIDTH = 31
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Command channel: an item is taken when start is high and busy is low.
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [DATA_WIDTH-1:0] value,
	// Result channel: done marks the single cycle in which the result is shown.
	output logic                       done,
	output logic [DATA_WIDTH-1:0]      inverse,
	output logic [DATA_WIDTH-1:0]      gcd_value,
	output logic                       no_inverse,
	// Modulus write channel.
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [DATA_WIDTH-1:0] modulus
);

	mie_cmd_t cmd;
	mie_sts_t sts;

	// The modulus register can always take a write. Writes are expected only while idle.
	assign cfg_ready = 1'b1;

	// The controller walks each Euclid step through alignment of the divisor, one
	// quotient bit per cycle of restoring division, and the pair update.
	mie_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// The datapath holds the remainder and coefficient pairs. While dividing it
	// also accumulates quotient times coefficient so that the new coefficient is
	// ready at the end of the step without a multiplier.
	mie_datapath #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid),
		.cfg_modulus (modulus),
		.value       (value),
		.cmd         (cmd),
		.sts         (sts),
		.inverse     (inverse),
		.gcd_value   (gcd_value),
		.no_inverse  (no_inverse)
	);

endmodule
`default_nettype wire

// ===== rtl/core/mie_checker.sv =====
// Port-level assertions of the modular inverse unit and their binding.
`default_nettype none
`include "modular_inverse_ext_euclid_unit_defines.svh"
module mie_checker #(
	parameter int DATA_WIDTH = 31
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  start,
	input wire logic                  busy,
	input wire logic                  done,
	input wire logic [DATA_WIDTH-1:0] gcd_value,
	input wire logic                  no_inverse
);

	`MIE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
	`MIE_ASSERT_SAME(a_done_idle, done, !busy, "result shown while still busy")
	`MIE_ASSERT_NEXT(a_done_single, done, !done, "result strobe lasted more than one cycle")
	`MIE_ASSERT_SAME(a_inv_gcd, done && !no_inverse, gcd_value == DATA_WIDTH'(1), "inverse flagged with gcd not one")
	`MIE_ASSERT_SAME(a_fall_done, $fell(busy), done, "item finished without a result")

endmodule

bind modular_inverse_ext_euclid_unit mie_checker #(
	.DATA_WIDTH (DATA_WIDTH)
) u_mie_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.gcd_value  (gcd_value),
	.no_inverse (no_inverse)
);
`default_nettype wire
